### rtl/mnee_pkg.sv
// ----------------------------------------------------------------------------
// mnee_pkg
// Shared types, codes and the duration table of the note event encoder.
// ----------------------------------------------------------------------------
package mnee_pkg;

    typedef enum logic [2:0] {
        CMD_NOTE  = 3'd0,
        CMD_ACT   = 3'd1,
        CMD_DEACT = 3'd2,
        CMD_WAVE  = 3'd3,
        CMD_ABS   = 3'd4
    } t_cmd;

    localparam logic [7:0] TIME_INACTIVE = 8'hFF;
    localparam logic [7:0] CODE_LONG     = 8'h60;
    localparam logic [7:0] CODE_REST     = 8'h80;
    localparam logic [7:0] CODE_DEACT    = 8'h80;
    localparam logic [7:0] CODE_ACT      = 8'h90;
    localparam logic [6:0] PITCH_TOP     = 7'd61;
    localparam logic [3:0] NOTE_MASK     = 4'hF;
    localparam logic [2:0] OCT_DEFAULT   = 3'd4;
    localparam logic [4:0] WAVE_COUNT    = 5'd16;

    typedef struct packed {
        logic voice_mismatch;
        logic pitch_error;
        logic no_voice_free;
        logic control_in_event;
        logic bad_argument;
    } t_flags;

    // up to three code bytes for one item, nb = 0 means none
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nb;
        t_flags          flags;
    } t_pkt;

    function automatic logic [7:0] f_time(input logic [3:0] dur);
        logic [7:0] t;
        unique case (dur)
            4'd1:    t = 8'd192;
            4'd2:    t = 8'd144;
            4'd3:    t = 8'd96;
            4'd4:    t = 8'd72;
            4'd5:    t = 8'd64;
            4'd6:    t = 8'd48;
            4'd7:    t = 8'd36;
            4'd8:    t = 8'd32;
            4'd9:    t = 8'd24;
            4'd10:   t = 8'd18;
            4'd11:   t = 8'd16;
            4'd12:   t = 8'd12;
            4'd13:   t = 8'd9;
            4'd14:   t = 8'd8;
            4'd15:   t = 8'd6;
            default: t = 8'd0;
        endcase
        return t;
    endfunction

endpackage

### rtl/multivoice_note_event_encoder.sv
// ----------------------------------------------------------------------------
// multivoice_note_event_encoder
// Codes parsed note and voice control items into player object code bytes.
// ----------------------------------------------------------------------------
// Results: an item's packet passes the two-entry queue and the output register
// before its first result shows; then one result per cycle while i_ready is high.
// An item gives one result per code byte, or one result if it emits none.
// The front takes one item per cycle while the two-entry queue has room.
// Reset (synchronous, active low) marks all voices inactive, forces absolute
// coding, closes the event and empties the queue and output stage.
module multivoice_note_event_encoder #(
    parameter int VOICE_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_cmd,
    input  logic [2:0] i_voice_number,
    input  logic       i_is_rest,
    input  logic [3:0] i_pitch_class,
    input  logic [2:0] i_octave_given,
    input  logic [3:0] i_duration_code,
    input  logic [4:0] i_waveform_number,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic       o_voice_mismatch,
    output logic       o_pitch_error,
    output logic       o_no_voice_free,
    output logic       o_control_in_event,
    output logic       o_bad_argument
);
    import mnee_pkg::*;

    logic push;
    t_pkt push_pkt;
    logic q_full;
    logic q_valid;
    t_pkt q_pkt;
    logic pop;

    mnee_front #(.VOICE_COUNT(VOICE_COUNT)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_voice_number    (i_voice_number),
        .i_is_rest         (i_is_rest),
        .i_pitch_class     (i_pitch_class),
        .i_octave_given    (i_octave_given),
        .i_duration_code   (i_duration_code),
        .i_waveform_number (i_waveform_number),
        .i_full            (q_full),
        .o_push            (push),
        .o_pkt             (push_pkt)
    );

    mnee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_pkt   (q_pkt)
    );

    mnee_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_pkt              (q_pkt),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_code_byte        (o_code_byte),
        .o_byte_valid       (o_byte_valid),
        .o_last             (o_last),
        .o_voice_mismatch   (o_voice_mismatch),
        .o_pitch_error      (o_pitch_error),
        .o_no_voice_free    (o_no_voice_free),
        .o_control_in_event (o_control_in_event),
        .o_bad_argument     (o_bad_argument)
    );

endmodule

### rtl/mnee_front.sv
// ----------------------------------------------------------------------------
// mnee_front
// Accepts items, updates voice and event state, builds the byte packet.
// ----------------------------------------------------------------------------
module mnee_front #(
    parameter int VOICE_COUNT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_cmd,
    input  logic [2:0]    i_voice_number,
    input  logic          i_is_rest,
    input  logic [3:0]    i_pitch_class,
    input  logic [2:0]    i_octave_given,
    input  logic [3:0]    i_duration_code,
    input  logic [4:0]    i_waveform_number,
    input  logic          i_full,
    output logic          o_push,
    output mnee_pkg::t_pkt o_pkt
);
    import mnee_pkg::*;

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    logic [VOICE_COUNT-1:0][3:0] r_wave,  n_wave;
    logic [VOICE_COUNT-1:0][7:0] r_time,  n_time;
    logic [VOICE_COUNT-1:0][5:0] r_lastp, n_lastp;
    logic [VOICE_COUNT-1:0][2:0] r_oct,   n_oct;
    logic [VOICE_COUNT-1:0]      r_force, n_force;
    logic                        r_open,  n_open;
    logic [VW-1:0]               r_next,  n_next;

    t_cmd                        cmd;
    logic                        any_act;
    logic [VW-1:0]               from_idx;
    logic                        found;
    logic [VW-1:0]               v;
    logic [2:0]                  oct_sel;
    logic                        oct_err;
    logic [6:0]                  ap_raw;
    logic                        ap_bad;
    logic [6:0]                  ap;
    logic signed [7:0]           diff;
    logic                        rel_ok;
    logic [7:0]                  new_time;
    logic [VOICE_COUNT-1:0][7:0] t_after;
    logic                        more_wait;
    logic [7:0]                  least;
    logic                        vnum_ok;
    logic [VW-1:0]               vnum_idx;

    assign cmd     = t_cmd'(i_cmd);
    assign o_ready = !i_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        any_act = 1'b0;
        for (int i = 0; i < VOICE_COUNT; i++) begin
            if (r_time[i] != TIME_INACTIVE) any_act = 1'b1;
        end
    end

    assign from_idx = r_open ? r_next : '0;

    // lowest waiting voice at or above the event's position
    always_comb begin
        found = 1'b0;
        v     = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (r_time[i] == 8'd0 && i >= int'(from_idx)) begin
                found = 1'b1;
                v     = VW'(i);
            end
        end
    end

    always_comb begin
        oct_err = 1'b0;
        oct_sel = i_octave_given;
        if (i_octave_given == 3'd0) begin
            oct_sel = r_oct[v];
            if (r_oct[v] == 3'd0) begin
                oct_err = 1'b1;
                oct_sel = OCT_DEFAULT;
            end
        end
    end

    assign ap_raw  = 7'(oct_sel) * 7'd12 + 7'(i_pitch_class) - 7'd12;
    assign ap_bad  = (ap_raw == 7'd0) || (ap_raw > PITCH_TOP);
    assign ap      = ap_bad ? PITCH_TOP : ap_raw;
    assign diff    = $signed({1'b0, ap}) - $signed({2'b00, r_lastp[v]});
    assign rel_ok  = !r_force[v] && (r_lastp[v] != 6'd0) &&
                     (diff >= -8'sd7) && (diff <= 8'sd7);
    assign new_time = f_time(i_duration_code);

    always_comb begin
        more_wait = 1'b0;
        least     = TIME_INACTIVE;
        for (int i = 0; i < VOICE_COUNT; i++) begin
            t_after[i] = (VW'(i) == v) ? new_time : r_time[i];
        end
        for (int i = 0; i < VOICE_COUNT; i++) begin
            if (i > int'(v) && t_after[i] == 8'd0) more_wait = 1'b1;
            if (t_after[i] != TIME_INACTIVE && t_after[i] < least) least = t_after[i];
        end
    end

    assign vnum_ok  = (i_voice_number != 3'd0) &&
                      ({1'b0, i_voice_number} <= 4'(VOICE_COUNT));
    assign vnum_idx = VW'(i_voice_number - 3'd1);

    always_comb begin
        n_wave  = r_wave;
        n_time  = r_time;
        n_lastp = r_lastp;
        n_oct   = r_oct;
        n_force = r_force;
        n_open  = r_open;
        n_next  = r_next;
        o_pkt   = '0;
        unique case (cmd)
            CMD_NOTE: begin
                if (!r_open && !any_act) begin
                    o_pkt.flags.no_voice_free = 1'b1;
                end else begin
                    n_open = 1'b1;
                    n_next = from_idx;
                    if (!found) begin
                        o_pkt.flags.no_voice_free = 1'b1;
                    end else begin
                        o_pkt.flags.voice_mismatch = (i_voice_number != 3'd0) &&
                            ({1'b0, i_voice_number} != 4'(v) + 4'd1);
                        if (i_is_rest) begin
                            o_pkt.bytes[0] = CODE_REST | {4'd0, i_duration_code};
                            o_pkt.nb       = 2'd1;
                        end else begin
                            o_pkt.flags.pitch_error = oct_err || ap_bad;
                            n_oct[v]   = oct_sel;
                            n_lastp[v] = ap[5:0];
                            if (rel_ok) begin
                                o_pkt.bytes[0] = {diff[3:0] & NOTE_MASK, i_duration_code};
                                o_pkt.nb       = 2'd1;
                            end else begin
                                o_pkt.bytes[0] = CODE_LONG;
                                o_pkt.bytes[1] = {ap, 1'b0};
                                o_pkt.bytes[2] = {r_wave[v], i_duration_code};
                                o_pkt.nb       = 2'd3;
                            end
                        end
                        n_force[v] = 1'b0;
                        if (more_wait) begin
                            n_time = t_after;
                            n_next = VW'(32'(v) + 32'd1);
                        end else begin
                            // event complete: advance all active voices by the shortest
                            for (int i = 0; i < VOICE_COUNT; i++) begin
                                n_time[i] = (t_after[i] != TIME_INACTIVE) ?
                                            t_after[i] - least : t_after[i];
                            end
                            n_open = 1'b0;
                        end
                    end
                end
            end
            CMD_ACT, CMD_DEACT: begin
                if (!vnum_ok) begin
                    o_pkt.flags.bad_argument = 1'b1;
                end else begin
                    o_pkt.flags.control_in_event = r_open;
                    n_open         = 1'b0;
                    o_pkt.bytes[0] = (cmd == CMD_ACT) ? CODE_ACT : CODE_DEACT;
                    o_pkt.bytes[1] = 8'(vnum_idx);
                    o_pkt.nb       = 2'd2;
                    n_time[vnum_idx] = (cmd == CMD_ACT) ? 8'd0 : TIME_INACTIVE;
                end
            end
            CMD_WAVE: begin
                if (!vnum_ok || i_waveform_number == 5'd0 ||
                    i_waveform_number > WAVE_COUNT) begin
                    o_pkt.flags.bad_argument = 1'b1;
                end else begin
                    n_force[vnum_idx] = 1'b1;
                    n_wave[vnum_idx]  = 4'(i_waveform_number - 5'd1);
                end
            end
            CMD_ABS: begin
                n_force = '1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_wave[i]  <= '0;
                r_time[i]  <= TIME_INACTIVE;
                r_lastp[i] <= '0;
                r_oct[i]   <= '0;
            end
            r_force <= '1;
            r_open  <= 1'b0;
            r_next  <= '0;
        end else if (o_push) begin
            r_wave  <= n_wave;
            r_time  <= n_time;
            r_lastp <= n_lastp;
            r_oct   <= n_oct;
            r_force <= n_force;
            r_open  <= n_open;
            r_next  <= n_next;
        end
    end

    a_free_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_pkt.flags.no_voice_free |-> o_pkt.nb == 2'd0 ##1 $stable(r_time))
        else $error("no free voice but bytes emitted");

    a_bad_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_pkt.flags.bad_argument |=> $stable(r_time) && $stable(r_wave))
        else $error("ignored command changed voice state");

    a_ctl_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_pkt.flags.control_in_event |=> !r_open)
        else $error("control inside event left event open");

endmodule

### rtl/mnee_queue.sv
// ----------------------------------------------------------------------------
// mnee_queue
// Two-entry packet queue between the classify and emit sides.
// ----------------------------------------------------------------------------
module mnee_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mnee_pkg::t_pkt i_pkt,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mnee_pkg::t_pkt o_pkt
);
    import mnee_pkg::*;

    t_pkt       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pkt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### rtl/mnee_back.sv
// ----------------------------------------------------------------------------
// mnee_back
// Takes packets from the queue and sends them out one result per byte, or one result for a packet with no bytes.
// ----------------------------------------------------------------------------
module mnee_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mnee_pkg::t_pkt i_pkt,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_code_byte,
    output logic           o_byte_valid,
    output logic           o_last,
    output logic           o_voice_mismatch,
    output logic           o_pitch_error,
    output logic           o_no_voice_free,
    output logic           o_control_in_event,
    output logic           o_bad_argument
);
    import mnee_pkg::*;

    logic       r_have;
    t_pkt       r_pkt;
    logic [1:0] r_idx;
    logic [1:0] last_idx;
    logic       done;

    assign last_idx = (r_pkt.nb == 2'd0) ? 2'd0 : r_pkt.nb - 2'd1;
    assign done     = r_have && i_ready && (r_idx == last_idx);
    assign o_pop    = i_q_valid && (!r_have || done);

    assign o_valid            = r_have;
    assign o_byte_valid       = (r_pkt.nb != 2'd0);
    assign o_code_byte        = o_byte_valid ? r_pkt.bytes[r_idx] : 8'd0;
    assign o_last             = (r_idx == last_idx);
    assign o_voice_mismatch   = r_pkt.flags.voice_mismatch;
    assign o_pitch_error      = r_pkt.flags.pitch_error;
    assign o_no_voice_free    = r_pkt.flags.no_voice_free;
    assign o_control_in_event = r_pkt.flags.control_in_event;
    assign o_bad_argument     = r_pkt.flags.bad_argument;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_pkt <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_have <= 1'b0;
            r_idx  <= 2'd0;
        end else if (r_have && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

### tb/sv/multivoice_note_event_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multivoice_note_event_encoder_test
// Feeds note, rest and voice control items into the encoder with random
// sender bursts and receiver stalls. A voice model kept in the bench works
// out the code bytes and flags of every item (a directed item with a result
// fixed by hand uses that one), and the bench compares each output transfer with them in order.
// ----------------------------------------------------------------------------
module multivoice_note_event_encoder_test;
    import mnee_pkg::*;

    localparam int VOICES       = 4;
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 460;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // ticks per duration code, code 15 first
    localparam logic [15:0][7:0] DUR_TICKS = {
        8'd6, 8'd8, 8'd9, 8'd12, 8'd16, 8'd18, 8'd24, 8'd32,
        8'd36, 8'd48, 8'd64, 8'd72, 8'd96, 8'd144, 8'd192, 8'd0
    };

    localparam t_flags FL_NONE = 5'b00000;
    localparam t_flags FL_FREE = 5'b00100;
    localparam t_flags FL_CTL  = 5'b00010;
    localparam t_flags FL_BAD  = 5'b00001;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [2:0]      vnum;
        logic            is_rest;
        logic [3:0]      pc;
        logic [2:0]      oct;
        logic [3:0]      dur;
        logic [4:0]      wav;
        logic            typed;   // result below is fixed by hand
        logic [1:0]      nb;
        logic [2:0][7:0] bytes;
        t_flags          flags;
    } t_note_item;

    typedef struct packed {
        logic [7:0] code;
        logic       byte_valid;
        logic       last;
        t_flags     flags;
    } t_code_out;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic       i_ready           = 1'b0;
    logic [2:0] i_cmd             = '0;
    logic [2:0] i_voice_number    = '0;
    logic       i_is_rest         = 1'b0;
    logic [3:0] i_pitch_class     = '0;
    logic [2:0] i_octave_given    = '0;
    logic [3:0] i_duration_code   = '0;
    logic [4:0] i_waveform_number = '0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_code_byte;
    logic       o_byte_valid;
    logic       o_last;
    logic       o_voice_mismatch;
    logic       o_pitch_error;
    logic       o_no_voice_free;
    logic       o_control_in_event;
    logic       o_bad_argument;

    multivoice_note_event_encoder #(
        .VOICE_COUNT(VOICES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_voice_number     (i_voice_number),
        .i_is_rest          (i_is_rest),
        .i_pitch_class      (i_pitch_class),
        .i_octave_given     (i_octave_given),
        .i_duration_code    (i_duration_code),
        .i_waveform_number  (i_waveform_number),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_code_byte        (o_code_byte),
        .o_byte_valid       (o_byte_valid),
        .o_last             (o_last),
        .o_voice_mismatch   (o_voice_mismatch),
        .o_pitch_error      (o_pitch_error),
        .o_no_voice_free    (o_no_voice_free),
        .o_control_in_event (o_control_in_event),
        .o_bad_argument     (o_bad_argument)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // voice model
    logic [3:0] voice_wave   [VOICES];
    logic [7:0] voice_ticks  [VOICES];
    logic [5:0] voice_pitch  [VOICES];
    logic [2:0] voice_oct    [VOICES];
    logic       voice_forced [VOICES];
    logic       event_open;
    logic [2:0] event_slot;

    t_code_out  code_expect_q [$];
    t_note_item directed [N_DIRECTED];
    int         mismatch_count = 0;
    int         burst_left     = 0;
    int         idle_cycles    = 0;

    function automatic int first_waiting(input int from);
        for (int i = from; i < VOICES; i++)
            if (voice_ticks[i] == 8'd0)
                return i;
        return -1;
    endfunction

    function automatic bit any_live_voice();
        for (int i = 0; i < VOICES; i++)
            if (voice_ticks[i] != TIME_INACTIVE)
                return 1'b1;
        return 1'b0;
    endfunction

    // event complete: advance all active voices by the shortest time left
    task automatic close_event();
        logic [7:0] least;
        least = TIME_INACTIVE;
        for (int i = 0; i < VOICES; i++)
            if (voice_ticks[i] != TIME_INACTIVE && voice_ticks[i] < least)
                least = voice_ticks[i];
        for (int i = 0; i < VOICES; i++)
            if (voice_ticks[i] != TIME_INACTIVE)
                voice_ticks[i] = voice_ticks[i] - least;
        event_open = 1'b0;
    endtask

    task automatic predict_codes(inout t_note_item it);
        int         v;
        int         ap;
        int         diff;
        logic [2:0] oct;
        it.nb    = '0;
        it.bytes = '0;
        it.flags = FL_NONE;
        case (it.cmd)
            CMD_NOTE: begin
                v = -1;
                if (!event_open && !any_live_voice()) begin
                    it.flags.no_voice_free = 1'b1;
                end else begin
                    if (!event_open) begin
                        event_slot = '0;
                        event_open = 1'b1;
                    end
                    v = first_waiting(int'(event_slot));
                    if (v < 0)
                        it.flags.no_voice_free = 1'b1;
                end
                if (v >= 0) begin
                    if (it.vnum != 0 && v + 1 != int'(it.vnum))
                        it.flags.voice_mismatch = 1'b1;
                    if (it.is_rest) begin
                        it.bytes[0] = CODE_REST | {4'h0, it.dur};
                        it.nb = 2'd1;
                    end else begin
                        oct = it.oct;
                        if (oct == 0) begin
                            oct = voice_oct[v];
                            if (oct == 0) begin
                                it.flags.pitch_error = 1'b1;
                                oct = OCT_DEFAULT;
                            end
                        end
                        voice_oct[v] = oct;
                        ap = int'(oct) * 12 + int'(it.pc) - 12;
                        if (ap < 1 || ap > int'(PITCH_TOP)) begin
                            it.flags.pitch_error = 1'b1;
                            ap = int'(PITCH_TOP);
                        end
                        diff = ap - int'(voice_pitch[v]);
                        if (!voice_forced[v] && voice_pitch[v] != 0 &&
                            diff >= -7 && diff <= 7) begin
                            it.bytes[0] = {diff[3:0] & NOTE_MASK, it.dur};
                            it.nb = 2'd1;
                        end else begin
                            it.bytes[0] = CODE_LONG;
                            it.bytes[1] = 8'(ap * 2);
                            it.bytes[2] = {voice_wave[v], it.dur};
                            it.nb = 2'd3;
                        end
                        voice_pitch[v] = 6'(ap);
                    end
                    voice_ticks[v]  = DUR_TICKS[it.dur];
                    voice_forced[v] = 1'b0;
                    if (first_waiting(v + 1) < 0)
                        close_event();
                    else
                        event_slot = 3'(v + 1);
                end
            end
            CMD_ACT, CMD_DEACT: begin
                if (it.vnum < 1 || it.vnum > VOICES) begin
                    it.flags.bad_argument = 1'b1;
                end else begin
                    if (event_open) begin
                        it.flags.control_in_event = 1'b1;
                        event_open = 1'b0;
                    end
                    it.bytes[0] = (it.cmd == CMD_ACT) ? CODE_ACT : CODE_DEACT;
                    it.bytes[1] = 8'(it.vnum - 1);
                    it.nb = 2'd2;
                    voice_ticks[it.vnum - 1] = (it.cmd == CMD_ACT) ? 8'd0 : TIME_INACTIVE;
                end
            end
            CMD_WAVE: begin
                if (it.wav < 1 || it.wav > WAVE_COUNT ||
                    it.vnum < 1 || it.vnum > VOICES) begin
                    it.flags.bad_argument = 1'b1;
                end else begin
                    voice_forced[it.vnum - 1] = 1'b1;
                    voice_wave[it.vnum - 1]   = 4'(it.wav - 1);
                end
            end
            CMD_ABS: begin
                for (int i = 0; i < VOICES; i++)
                    voice_forced[i] = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic t_note_item make_item(
        input logic [2:0] cmd,
        input logic [2:0] vnum,
        input logic       is_rest,
        input logic [3:0] pc,
        input logic [2:0] oct,
        input logic [3:0] dur,
        input logic [4:0] wav
    );
        t_note_item it;
        it         = '0;
        it.cmd     = cmd;
        it.vnum    = vnum;
        it.is_rest = is_rest;
        it.pc      = pc;
        it.oct     = oct;
        it.dur     = dur;
        it.wav     = wav;
        return it;
    endfunction

    function automatic t_note_item with_result(
        input t_note_item it,
        input logic [1:0] nb,
        input logic [7:0] b0,
        input logic [7:0] b1,
        input t_flags     fl
    );
        t_note_item r;
        r          = it;
        r.typed    = 1'b1;
        r.nb       = nb;
        r.bytes    = '0;
        r.bytes[0] = b0;
        r.bytes[1] = b1;
        r.flags    = fl;
        return r;
    endfunction

    // sender works in bursts; between bursts a random gap may lower valid
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_item(input t_note_item it);
        t_note_item want;
        t_code_out  res;
        int         nres;
        i_cmd             <= it.cmd;
        i_voice_number    <= it.vnum;
        i_is_rest         <= it.is_rest;
        i_pitch_class     <= it.pc;
        i_octave_given    <= it.oct;
        i_duration_code   <= it.dur;
        i_waveform_number <= it.wav;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        want = it;
        predict_codes(want);
        if (it.typed)
            want = it;
        nres = (want.nb == 0) ? 1 : int'(want.nb);
        for (int k = 0; k < nres; k++) begin
            res.code       = (want.nb == 0) ? 8'd0 : want.bytes[k];
            res.byte_valid = (want.nb != 0);
            res.last       = (k == nres - 1);
            res.flags      = want.flags;
            code_expect_q.push_back(res);
        end
    endtask

    initial begin
        t_note_item it;
        int         pick;
        int         r;

        for (int i = 0; i < VOICES; i++) begin
            voice_wave[i]   = '0;
            voice_ticks[i]  = TIME_INACTIVE;
            voice_pitch[i]  = '0;
            voice_oct[i]    = '0;
            voice_forced[i] = 1'b1;
        end
        event_open = 1'b0;
        event_slot = '0;

        directed[0]  = with_result(make_item(CMD_NOTE, 3'd0, 1'b0, 4'd1, 3'd4, 4'd1, 5'd1),
                                   2'd0, 8'd0, 8'd0, FL_FREE);
        directed[1]  = with_result(make_item(CMD_ACT, 3'd0, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd0, 8'd0, 8'd0, FL_BAD);
        directed[2]  = with_result(make_item(CMD_DEACT, 3'd7, 1'b1, 4'd15, 3'd7, 4'd15, 5'd31),
                                   2'd0, 8'd0, 8'd0, FL_BAD);
        directed[3]  = with_result(make_item(CMD_WAVE, 3'd1, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd0, 8'd0, 8'd0, FL_BAD);
        directed[4]  = with_result(make_item(CMD_WAVE, 3'd1, 1'b0, 4'd0, 3'd0, 4'd0, 5'd31),
                                   2'd0, 8'd0, 8'd0, FL_BAD);
        directed[5]  = with_result(make_item(CMD_WAVE, 3'd1, 1'b0, 4'd0, 3'd0, 4'd0, 5'd16),
                                   2'd0, 8'd0, 8'd0, FL_NONE);
        directed[6]  = with_result(make_item(CMD_ACT, 3'd1, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd2, CODE_ACT, 8'd0, FL_NONE);
        directed[7]  = with_result(make_item(CMD_ACT, 3'd4, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd2, CODE_ACT, 8'd3, FL_NONE);
        // no octave yet on voice 1: falls back to the default octave
        directed[8]  = make_item(CMD_NOTE, 3'd0, 1'b0, 4'd1, 3'd0, 4'd1, 5'd0);
        directed[9]  = with_result(make_item(CMD_ACT, 3'd2, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd2, CODE_ACT, 8'd1, FL_CTL);
        directed[10] = make_item(CMD_NOTE, 3'd1, 1'b0, 4'd12, 3'd6, 4'd2, 5'd0);
        directed[11] = make_item(CMD_NOTE, 3'd4, 1'b1, 4'd0, 3'd0, 4'd15, 5'd0);
        directed[12] = make_item(CMD_NOTE, 3'd0, 1'b0, 4'd15, 3'd7, 4'd14, 5'd0);
        directed[13] = make_item(CMD_DEACT, 3'd2, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0);
        directed[14] = make_item(CMD_DEACT, 3'd4, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0);
        // open event with nothing waiting
        directed[15] = make_item(CMD_NOTE, 3'd0, 1'b0, 4'd5, 3'd3, 4'd3, 5'd0);
        directed[16] = make_item(CMD_ACT, 3'd1, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0);
        // steps of -12, +7, -7, +8 on the lone voice
        directed[17] = make_item(CMD_NOTE, 3'd1, 1'b0, 4'd1, 3'd3, 4'd3, 5'd0);
        directed[18] = make_item(CMD_NOTE, 3'd0, 1'b0, 4'd8, 3'd0, 4'd4, 5'd0);
        directed[19] = make_item(CMD_NOTE, 3'd0, 1'b0, 4'd1, 3'd3, 4'd5, 5'd0);
        directed[20] = make_item(CMD_NOTE, 3'd0, 1'b0, 4'd9, 3'd0, 4'd6, 5'd0);
        directed[21] = with_result(make_item(CMD_SPARE_LO, 3'd1, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd0, 8'd0, 8'd0, FL_NONE);
        directed[22] = with_result(make_item(CMD_SPARE_HI, 3'd7, 1'b1, 4'd15, 3'd7, 4'd15, 5'd31),
                                   2'd0, 8'd0, 8'd0, FL_NONE);
        directed[23] = with_result(make_item(CMD_ABS, 3'd0, 1'b0, 4'd0, 3'd0, 4'd0, 5'd0),
                                   2'd0, 8'd0, 8'd0, FL_NONE);
        // pitch below range, zero duration, wrong voice given
        directed[24] = make_item(CMD_NOTE, 3'd2, 1'b0, 4'd0, 3'd1, 4'd0, 5'd0);

        do @(posedge i_clk); while (!i_rst_n);

        for (int n = 0; n < N_DIRECTED; n++) begin
            pace_sender();
            send_item(directed[n]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it = make_item(3'($urandom), 3'($urandom), 1'($urandom), 4'($urandom),
                           3'($urandom), 4'($urandom), 5'($urandom));
            pick = $urandom_range(0, 99);
            if (!any_live_voice() && pick < 70)
                pick = 62;
            if (pick < 62) begin
                it.cmd     = CMD_NOTE;
                it.is_rest = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 19);
                if (r < 10)
                    it.vnum = 3'd0;
                else if (r < 17)
                    it.vnum = 3'($urandom_range(1, VOICES));
                r = $urandom_range(0, 19);
                if (r < 7)
                    it.oct = 3'd0;
                else if (r < 18)
                    it.oct = 3'($urandom_range(1, 6));
                if ($urandom_range(0, 9) != 0)
                    it.pc = 4'($urandom_range(1, 12));
                if ($urandom_range(0, 19) != 0)
                    it.dur = 4'($urandom_range(1, 15));
            end else if (pick < 74) begin
                it.cmd  = CMD_ACT;
                it.vnum = 3'($urandom_range(1, VOICES));
            end else if (pick < 82) begin
                it.cmd  = CMD_DEACT;
                it.vnum = 3'($urandom_range(1, VOICES));
            end else if (pick < 90) begin
                it.cmd  = CMD_WAVE;
                it.vnum = 3'($urandom_range(1, VOICES));
                if ($urandom_range(0, 6) != 0)
                    it.wav = 5'($urandom_range(1, WAVE_COUNT));
            end else if (pick < 94) begin
                it.cmd = CMD_ABS;
            end else if (pick < 97) begin
                it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end else begin
                it.cmd  = 3'($urandom_range(CMD_ACT, CMD_WAVE));
                it.vnum = ($urandom_range(0, 3) == 0) ? 3'd0
                                                      : 3'($urandom_range(VOICES + 1, 7));
            end
            pace_sender();
            send_item(it);
        end
        i_valid <= 1'b0;

        while (code_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && code_expect_q.size() == 0)
            $display("** multivoice_note_event_encoder: PASSED **");
        else
            $display("** multivoice_note_event_encoder: FAILED **");
        $finish;
    end

    // receiver: stall a fixed slice of each period, pattern re-drawn now and then
    int rx_hold   = 0;
    int rx_period = 1;
    int rx_stall  = 0;
    int rx_phase  = 0;

    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_period = $urandom_range(2, 9);
            rx_stall  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, rx_period - 1);
            rx_hold   = $urandom_range(16, 96);
            rx_phase  = 0;
        end
        rx_hold--;
        i_ready <= (rx_phase >= rx_stall);
        rx_phase = (rx_phase + 1) % rx_period;
    end

    task automatic report_mismatch(input string what, input t_code_out want,
                                   input t_code_out got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t %s: expected code=%02h bv=%0b last=%0b flags=%05b, ",
                      "got code=%02h bv=%0b last=%0b flags=%05b"},
                     $realtime, what, want.code, want.byte_valid, want.last, want.flags,
                     got.code, got.byte_valid, got.last, got.flags);
    endtask

    t_code_out got_res;
    t_code_out want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_res.code       = o_code_byte;
            got_res.byte_valid = o_byte_valid;
            got_res.last       = o_last;
            got_res.flags      = {o_voice_mismatch, o_pitch_error, o_no_voice_free,
                                  o_control_in_event, o_bad_argument};
            if (code_expect_q.size() == 0) begin
                report_mismatch("unexpected transfer", '0, got_res);
            end else begin
                want_res = code_expect_q.pop_front();
                if (got_res !== want_res)
                    report_mismatch("result mismatch", want_res, got_res);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** multivoice_note_event_encoder: FAILED **");
                $finish;
            end
        end
    end

endmodule

### sim.f
rtl/mnee_pkg.sv
rtl/mnee_front.sv
rtl/mnee_queue.sv
rtl/mnee_back.sv
rtl/multivoice_note_event_encoder.sv
tb/sv/multivoice_note_event_encoder_test.sv
